>>> sv/pqf_pkg.sv
// ============================================================================
// pqf_pkg
// Types, sizes and codes shared by the priority queue modules.
// ============================================================================
`default_nettype none

package pqf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SEV_W       = 16;
    localparam int TAG_W       = 16;
    localparam int SEQ_W       = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SEV_W-1:0] sev_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [SEQ_W-1:0] seq_t;

    // operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_INSERTED  = 2'd0;
    localparam logic [1:0] STAT_DROPPED   = 2'd1;
    localparam logic [1:0] STAT_EXTRACTED = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic op;
        sev_t severity;
        tag_t tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        tag_t       out_tag;
        sev_t       out_severity;
    } out_item_t;

    // one stored entry: severity, tag and arrival sequence
    typedef struct packed {
        sev_t severity;
        tag_t tag;
        seq_t seq;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/pqf_store.sv
// ============================================================================
// pqf_store
// Entry memory: one write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module pqf_store (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire pqf_pkg::idx_t   wr_addr,
    input  wire pqf_pkg::entry_t wr_data,
    input  wire pqf_pkg::idx_t   rd_addr,
    output pqf_pkg::entry_t      rd_data
);

    pqf_pkg::entry_t mem [pqf_pkg::QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/pqf_cmp.sv
// ============================================================================
// pqf_cmp
// Ordering unit: is the candidate entry ahead of the current best?
// ============================================================================
`default_nettype none

module pqf_cmp (
    input  wire pqf_pkg::entry_t cand,
    input  wire pqf_pkg::entry_t best,
    input  wire pqf_pkg::seq_t   arrival,
    output logic                 cand_first
);

    pqf_pkg::seq_t cand_age;
    pqf_pkg::seq_t best_age;

    // age is taken modulo the sequence width; older wins a severity tie
    assign cand_age = arrival - cand.seq;
    assign best_age = arrival - best.seq;

    always_comb begin
        if (cand.severity != best.severity) begin
            cand_first = cand.severity > best.severity;
        end else begin
            cand_first = cand_age > best_age;
        end
    end

endmodule

`default_nettype wire

>>> sv/priority_queue_fifo_tiebreak.sv
// ============================================================================
// priority_queue_fifo_tiebreak
// Bounded max-priority queue with oldest-first tie break, linear scan extract.
// ============================================================================
//
//  channel | ports                       | payload              | direction
//  --------+-----------------------------+----------------------+----------
//  input   | s_valid, s_ready, s_item    | op, severity, tag    | in
//  result  | m_valid, m_ready, m_item    | status, tag, severity| out
//
//  Insert, drop on full, extract on empty: the result is registered in the
//  sequencer, then in the output register. Extract: one shared compare unit
//  walks the entry memory one read per cycle, so occupancy sets the scan length.
//  Sync active-low reset empties the queue and zeroes the arrival counter.
//  A stalled result sits in the output register; the next item is taken
//  meanwhile and its result waits in the sequencer until the register frees.
// ============================================================================
`default_nettype none

module priority_queue_fifo_tiebreak (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pqf_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pqf_pkg::out_item_t     m_item
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    pqf_pkg::cnt_t      occ_reg, occ_next;        // valid entries
    pqf_pkg::seq_t      arr_reg, arr_next;        // arrival counter
    pqf_pkg::idx_t      scan_reg, scan_next;      // index of entry in rd_data
    pqf_pkg::entry_t    best_reg, best_next;      // best entry so far
    pqf_pkg::idx_t      bidx_reg, bidx_next;      // its memory index
    pqf_pkg::out_item_t res_reg, res_next;        // result waiting for output
    logic               m_valid_reg, m_valid_next;
    pqf_pkg::out_item_t m_item_reg, m_item_next;

    logic            in_fire;
    logic            full;
    logic            wr_en;
    pqf_pkg::idx_t   wr_addr;
    pqf_pkg::entry_t wr_data;
    pqf_pkg::idx_t   rd_addr;
    pqf_pkg::entry_t rd_data;
    logic            cand_first;
    logic            take;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;
    assign full    = (occ_reg == pqf_pkg::cnt_t'(pqf_pkg::QUEUE_DEPTH));
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the scan reads one entry ahead of the one being compared
    assign rd_addr = (state_reg == ST_SCAN) ? pqf_pkg::idx_t'(scan_reg + 1'b1) : '0;

    pqf_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pqf_cmp u_cmp (
        .cand       (rd_data),
        .best       (best_reg),
        .arrival    (arr_reg),
        .cand_first (cand_first)
    );

    // first entry of a scan always becomes the running best
    assign take = (scan_reg == '0) || cand_first;

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        arr_next     = arr_reg;
        scan_next    = scan_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_addr      = occ_reg[pqf_pkg::IDX_W-1:0];
        wr_data      = '{severity: s_item.severity, tag: s_item.tag, seq: arr_reg};
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_RESP;
                    if (s_item.op == pqf_pkg::OP_INSERT) begin
                        if (full) begin
                            res_next = '{status: pqf_pkg::STAT_DROPPED,
                                         out_tag: '0, out_severity: '0};
                        end else begin
                            // append at the end; counter stamps the entry
                            wr_en    = 1'b1;
                            occ_next = occ_reg + 1'b1;
                            arr_next = arr_reg + 1'b1;
                            res_next = '{status: pqf_pkg::STAT_INSERTED,
                                         out_tag: '0, out_severity: '0};
                        end
                    end else if (occ_reg == '0) begin
                        res_next = '{status: pqf_pkg::STAT_EMPTY,
                                     out_tag: '0, out_severity: '0};
                    end else begin
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (take) begin
                    best_next = rd_data;
                    bidx_next = scan_reg;
                end
                if (pqf_pkg::cnt_t'(scan_reg) == occ_reg - 1'b1) begin
                    // last entry fills the hole left by the winner
                    wr_en      = 1'b1;
                    wr_addr    = bidx_next;
                    wr_data    = rd_data;
                    occ_next   = occ_reg - 1'b1;
                    res_next   = '{status: pqf_pkg::STAT_EXTRACTED,
                                   out_tag: best_next.tag,
                                   out_severity: best_next.severity};
                    state_next = ST_RESP;
                end else begin
                    scan_next = pqf_pkg::idx_t'(scan_reg + 1'b1);
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            arr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            arr_reg     <= arr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

endmodule

`default_nettype wire

>>> sv/pqf_check.sv
// ============================================================================
// pqf_check
// Port-level checks for the priority queue, bound to the top level.
// ============================================================================
`default_nettype none

module pqf_check (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire pqf_pkg::in_item_t  s_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pqf_pkg::out_item_t m_item
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // only an extract carries a tag and severity
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != pqf_pkg::STAT_EXTRACTED |->
            m_item.out_tag == '0 && m_item.out_severity == '0)
        else $error("non-extract result with payload");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while busy");

    // a new result only comes from a busy sequencer
    a_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without a pending item");

endmodule

bind priority_queue_fifo_tiebreak pqf_check u_pqf_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
